// ===== sv/rtyc_pkg.sv =====
// Shared types, constants and the coefficient function of the RGB to YCbCr converter.
// No dependencies.
package rtyc_pkg;

    localparam int COEF_BITS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF = 2;
    localparam int COMP_W         = 8;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } pixel_t;

    localparam int PIXEL_W = $bits(pixel_t);

    // Rounds num/10000 half up to the given fraction bits, saturated just below one.
    function automatic longint coef_val(input longint num, input int bits);
        longint one;
        longint q;
        one = longint'(1) << bits;
        q   = (num * one + 64'sd5000) / 64'sd10000;
        if (q > one - 1) begin
            q = one - 1;
        end
        return q;
    endfunction

endpackage

// ===== sv/rgb_to_ycbcr_converter.sv =====
// Top level of the RGB to YCbCr converter (JFIF full range).
// Depends on rtyc_pkg, rtyc_front, rtyc_fifo and rtyc_back.

// The block takes one colour byte per transfer in the repeating order red, green,
// blue and answers each pixel with three transfers, Y, Cb and Cr, the last one
// flagged by m_last. Both sides sustain one transfer per cycle while m_ready stays
// high: the front stage holds red and green and queues the pixel on blue, and the
// conversion pipeline issues one result per cycle from that queue, so three bytes
// in match three bytes out. Y follows the blue transfer through the queue, written
// at the transfer edge, then the multiplier stage and the sum-and-clamp output
// register.
// Coefficients carry COEF_BITS fraction bits and are rounded at elaboration.
module rgb_to_ycbcr_converter
    import rtyc_pkg::*;
#(
    parameter int COEF_BITS  = COEF_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [COMP_W-1:0] s_component,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COMP_W-1:0] m_value,
    output logic              m_last
);

    logic             push_valid;
    logic             push_ready;
    pixel_t           push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [PIXEL_W-1:0] pop_bits;

    rtyc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_component (s_component),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    rtyc_fifo #(
        .WIDTH (PIXEL_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_bits)
    );

    rtyc_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pop_valid),
        .in_ready (pop_ready),
        .in_data  (pixel_t'(pop_bits)),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_last   (m_last)
    );

endmodule

// ===== sv/rtyc_front.sv =====
// Input side of the RGB to YCbCr converter: holds red and green and forms one pixel on blue.
// Depends on rtyc_pkg.
module rtyc_front
    import rtyc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [COMP_W-1:0] s_component,
    output logic              push_valid,
    input  logic              push_ready,
    output pixel_t            push_data
);

    localparam logic [1:0] POS_RED   = 2'd0;
    localparam logic [1:0] POS_GREEN = 2'd1;

    logic [1:0]        pos_reg;
    logic [1:0]        pos_next;
    logic [COMP_W-1:0] red_reg;
    logic [COMP_W-1:0] green_reg;
    logic              is_blue;
    logic              accept;

    assign is_blue    = pos_reg[1];
    assign s_ready    = !is_blue || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid && is_blue;
    assign push_data  = '{red: red_reg, green: green_reg, blue: s_component};

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (is_blue) begin
                pos_next = POS_RED;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_RED;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pos_reg == POS_RED) begin
            red_reg <= s_component;
        end
        if (accept && pos_reg == POS_GREEN) begin
            green_reg <= s_component;
        end
    end

endmodule

// ===== sv/rtyc_fifo.sv =====
// Small register queue that decouples pixel collection from the conversion pipeline.
// Depends on rtyc_pkg for its default width and depth.
module rtyc_fifo
    import rtyc_pkg::*;
#(
    parameter int WIDTH = PIXEL_W,
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== sv/rtyc_back.sv =====
// Conversion pipeline: emits Y, Cb and Cr of each queued pixel, one per cycle while m_ready is high.
// Depends on rtyc_pkg for the pixel type and the coefficient function.
module rtyc_back
    import rtyc_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pixel_t            in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COMP_W-1:0] m_value,
    output logic              m_last
);

    localparam int CW    = COEF_BITS + 1;
    localparam int PW    = CW + COMP_W + 1;
    localparam int ACC_W = COEF_BITS + 11;

    localparam logic [1:0] SEL_Y  = 2'd0;
    localparam logic [1:0] SEL_CB = 2'd1;
    localparam logic [1:0] SEL_CR = 2'd2;

    localparam logic signed [CW-1:0] C_YR  = CW'(coef_val(2990, COEF_BITS));
    localparam logic signed [CW-1:0] C_YG  = CW'(coef_val(5870, COEF_BITS));
    localparam logic signed [CW-1:0] C_YB  = CW'(coef_val(1140, COEF_BITS));
    localparam logic signed [CW-1:0] C_CBR = CW'(-coef_val(1687, COEF_BITS));
    localparam logic signed [CW-1:0] C_CBG = CW'(-coef_val(3313, COEF_BITS));
    localparam logic signed [CW-1:0] C_HALF = CW'(coef_val(5000, COEF_BITS));
    localparam logic signed [CW-1:0] C_CRG = CW'(-coef_val(4187, COEF_BITS));
    localparam logic signed [CW-1:0] C_CRB = CW'(-coef_val(813, COEF_BITS));
    localparam logic signed [ACC_W-1:0] OFFSET = ACC_W'(longint'(128) << COEF_BITS);

    logic [1:0]             sel_reg;
    logic [1:0]             sel_next;
    logic                   p_valid_reg;
    logic [1:0]             p_sel_reg;
    logic signed [PW-1:0]   p_r_reg;
    logic signed [PW-1:0]   p_g_reg;
    logic signed [PW-1:0]   p_b_reg;
    logic                   m_valid_reg;
    logic [COMP_W-1:0]      m_value_reg;
    logic                   m_last_reg;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   load;
    logic                   pop;
    logic signed [CW-1:0]   k_r;
    logic signed [CW-1:0]   k_g;
    logic signed [CW-1:0]   k_b;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-COEF_BITS-1:0] whole;
    logic [COMP_W-1:0]      value_calc;

    assign s2_ready = !m_valid_reg || m_ready;
    assign s1_ready = !p_valid_reg || s2_ready;
    assign load     = in_valid && s1_ready;
    assign in_ready = s1_ready && sel_reg == SEL_CR;
    assign pop      = in_valid && in_ready;

    always_comb begin
        case (sel_reg)
            SEL_Y: begin
                k_r = C_YR;
                k_g = C_YG;
                k_b = C_YB;
            end
            SEL_CB: begin
                k_r = C_CBR;
                k_g = C_CBG;
                k_b = C_HALF;
            end
            SEL_CR: begin
                k_r = C_HALF;
                k_g = C_CRG;
                k_b = C_CRB;
            end
            default: begin
                k_r = C_HALF;
                k_g = C_CRG;
                k_b = C_CRB;
            end
        endcase
    end

    always_comb begin
        sel_next = sel_reg;
        if (load) begin
            sel_next = (sel_reg == SEL_CR) ? SEL_Y : sel_reg + 2'd1;
        end
    end

    always_comb begin
        acc = ACC_W'(p_r_reg) + ACC_W'(p_g_reg) + ACC_W'(p_b_reg);
        if (p_sel_reg != SEL_Y) begin
            acc = acc + OFFSET;
        end
        whole = acc[ACC_W-1:COEF_BITS];
        if (acc[ACC_W-1]) begin
            value_calc = '0;
        end else if (whole[ACC_W-COEF_BITS-2:COMP_W] != '0) begin
            value_calc = '1;
        end else begin
            value_calc = whole[COMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= SEL_Y;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
            if (s1_ready) begin
                p_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                m_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            p_sel_reg <= sel_reg;
            p_r_reg   <= PW'(k_r) * PW'($signed({1'b0, in_data.red}));
            p_g_reg   <= PW'(k_g) * PW'($signed({1'b0, in_data.green}));
            p_b_reg   <= PW'(k_b) * PW'($signed({1'b0, in_data.blue}));
        end
        if (s2_ready && p_valid_reg) begin
            m_value_reg <= value_calc;
            m_last_reg  <= p_sel_reg == SEL_CR;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

`ifndef ASSERT_OFF
    a_sel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg != 2'd3)
        else $error("result selector left its range");
    a_pop_on_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> sel_reg == SEL_CR && load)
        else $error("pixel released before its Cr result was started");
    a_restart_y: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> sel_reg == SEL_Y)
        else $error("selector did not return to Y after a pixel");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of rgb_to_ycbcr_converter: random and directed colour bytes
// are checked against a bit-exact Y, Cb, Cr predictor. Depends on rtyc_pkg and the RTL.
module tb;
    import rtyc_pkg::*;

    localparam int COEF_BITS = COEF_BITS_DEF;
    localparam int CLK_HALF = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS = 66;
    localparam int REPORT_MAX = 10;

    localparam logic [1:0] SLOT_RED = 2'd0;
    localparam logic [1:0] SLOT_GREEN = 2'd1;
    localparam logic [1:0] SLOT_BLUE = 2'd2;

    class pixel_tracker;
        logic [1:0] slot;
        logic [COMP_W-1:0] red_byte;
        logic [COMP_W-1:0] green_byte;
        logic [COMP_W-1:0] pending_value[$];
        logic pending_last[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            slot = SLOT_RED;
            red_byte = '0;
            green_byte = '0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function longint frac_coef(input longint num);
            longint one;
            longint q;
            one = longint'(1) << COEF_BITS;
            q = (num * one + 5000) / 10000;
            if (q > one - 1) begin
                q = one - 1;
            end
            return q;
        endfunction

        function logic [COMP_W-1:0] to_byte(input longint acc);
            longint v;
            v = acc / (longint'(1) << COEF_BITS);
            if (v < 0) begin
                return '0;
            end
            if (v > 255) begin
                return 8'd255;
            end
            return v[COMP_W-1:0];
        endfunction

        function void note_component(input logic [COMP_W-1:0] c);
            longint r;
            longint g;
            longint b;
            longint offset;
            case (slot)
                SLOT_RED: begin
                    red_byte = c;
                    slot = SLOT_GREEN;
                end
                SLOT_GREEN: begin
                    green_byte = c;
                    slot = SLOT_BLUE;
                end
                default: begin
                    r = longint'(red_byte);
                    g = longint'(green_byte);
                    b = longint'(c);
                    offset = longint'(128) << COEF_BITS;
                    pending_value.push_back(to_byte(frac_coef(2990) * r
                        + frac_coef(5870) * g + frac_coef(1140) * b));
                    pending_last.push_back(1'b0);
                    pending_value.push_back(to_byte(-frac_coef(1687) * r
                        - frac_coef(3313) * g + frac_coef(5000) * b + offset));
                    pending_last.push_back(1'b0);
                    pending_value.push_back(to_byte(frac_coef(5000) * r
                        - frac_coef(4187) * g - frac_coef(813) * b + offset));
                    pending_last.push_back(1'b1);
                    slot = SLOT_RED;
                end
            endcase
        endfunction

        function void check_result(input logic [COMP_W-1:0] value, input logic last);
            logic [COMP_W-1:0] want_value;
            logic want_last;
            results_seen++;
            if (pending_value.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result %0d: value %0d last %0b",
                             results_seen, value, last);
                end
                return;
            end
            want_value = pending_value.pop_front();
            want_last = pending_last.pop_front();
            if (value !== want_value || last !== want_last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch on result %0d: expected %0d/%0b, got %0d/%0b",
                             results_seen, want_value, want_last, value, last);
                end
            end
        endfunction

        function int pending();
            return pending_value.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [COMP_W-1:0] s_component;
    logic m_valid;
    logic m_ready;
    logic [COMP_W-1:0] m_value;
    logic m_last;

    pixel_tracker tracker = new();
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int idle_cycles;

    rgb_to_ycbcr_converter #(
        .COEF_BITS(COEF_BITS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_component(s_component),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_value(m_value),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #CLK_HALF aclk = ~aclk;
        end
    end

    task automatic send_component(input logic [COMP_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_component <= c;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        tracker.note_component(c);
        @(negedge aclk);
    endtask

    task automatic send_pixel(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                              input logic [COMP_W-1:0] b);
        send_component(r);
        send_component(g);
        send_component(b);
    endtask

    function automatic logic [COMP_W-1:0] random_component();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return '0;
        end
        if (pick < 10) begin
            return 8'd255;
        end
        return COMP_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random(input int count);
        repeat (count) begin
            send_component(random_component());
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_value, m_last);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_component = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The directed pixels drive every output to both ends of its range.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd170);

        send_random(PHASE_ITEMS);

        send_idle_pct = 80;
        recv_stall_pct = 0;
        send_random(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_stall_pct = 80;
        send_random(PHASE_ITEMS);

        send_idle_pct = 16;
        recv_stall_pct = 16;
        send_random(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        send_random(30);

        s_valid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rtyc_pkg.sv
sv/rtyc_front.sv
sv/rtyc_fifo.sv
sv/rtyc_back.sv
sv/rgb_to_ycbcr_converter.sv
tb/tb.sv
